// ===== hdl/fbpa_pkg.sv =====
`default_nettype none

package fbpa_pkg;

   // Pool geometry limits.
   localparam int NUM_BLOCKS      = 256;
   localparam int MAX_BLOCK_BYTES = 4096;
   localparam int INDEX_W         = $clog2(NUM_BLOCKS);

   localparam logic [12:0] BYTES_MIN  = 13'd8;
   localparam logic [12:0] BYTES_MAX  = 13'(MAX_BLOCK_BYTES);
   localparam logic [8:0]  BLOCKS_MIN = 9'd1;
   localparam logic [8:0]  BLOCKS_MAX = 9'(NUM_BLOCKS);
   localparam logic [8:0]  FREE_SAT   = 9'd511;

   // Reset values of the two configuration registers.
   localparam logic [12:0] BYTES_RESET  = 13'd8;
   localparam logic [8:0]  BLOCKS_RESET = 9'd256;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_BLOCK_BYTES = 1'b0,
      CSR_POOL_BLOCKS = 1'b1
   } csr_index_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // latch the request and start the link read
      logic commit;   // update pool state and load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy; // result register holds an item that is not taken this cycle
   } stat_type;

   // Block size clamped to the supported range.
   function automatic logic [12:0] eff_bytes(input logic [12:0] raw);
      logic [12:0] b;
      b = raw;
      if (b < BYTES_MIN) b = BYTES_MIN;
      if (b > BYTES_MAX) b = BYTES_MAX;
      return b;
   endfunction

   // Pool size clamped to the supported range.
   function automatic logic [8:0] eff_blocks(input logic [8:0] raw);
      logic [8:0] n;
      n = raw;
      if (n == 9'd0) n = BLOCKS_MIN;
      if (n > BLOCKS_MAX) n = BLOCKS_MAX;
      return n;
   endfunction

   // Stride is the clamped size rounded up to a multiple of eight bytes.
   function automatic logic [12:0] stride_of(input logic [12:0] eff);
      logic [12:0] s;
      s = eff + 13'd7;
      return {s[12:3], 3'b000};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/fixed_block_pool_allocator.sv =====
`default_nettype none

// Channel   Ports                                   Direction  Handshake
// request   req_type, req_block_index               in         req_valid / req_ready
// result    rsp_status .. rsp_free_blocks           out        rsp_valid / rsp_ready
// config    csr_index, csr_data                     in         csr_valid / csr_ready
//
// The idle state accepts an item and reads the link below the free-list head from the
// synchronous link memory; the execute state updates the pool and loads the result. No
// new item is taken before the last one has committed. Reset is synchronous and active
// high; it restores 8-byte blocks, a 256-block pool and an empty free list, and the link
// memory needs no clearing pass. A stalled result holds the next item in its execute cycle;
// one item may be accepted while a finished result still waits to be taken.

module fixed_block_pool_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_block_index,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_given_index,
   output logic [19:0]      rsp_block_offset,
   output logic [12:0]      rsp_clear_bytes,
   output logic [8:0]       rsp_free_blocks,
   // Configuration channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [12:0] csr_data
);
   import fbpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Register writes must arrive only while the block is idle; the block does not enforce this and takes every write.
   assign csr_ready = 1'b1;

   // The controller sequences accept and commit; it never sees payload.
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the configuration, the free list, the link memory and the
   // result register, and computes offsets with one small multiplier.
   fbpa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_block_index  (req_block_index),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_given_index  (rsp_given_index),
      .rsp_block_offset (rsp_block_offset),
      .rsp_clear_bytes  (rsp_clear_bytes),
      .rsp_free_blocks  (rsp_free_blocks)
   );

endmodule

`default_nettype wire

// ===== hdl/fbpa_ctrl.sv =====
`default_nettype none

module fbpa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fbpa_pkg::stat_type stat,
   output fbpa_pkg::cmd_type      cmd
);
   import fbpa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The execute state waits only while the result register is still occupied.
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_commit_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (cmd.commit || state_ff == S_EXEC))
      else $error("accepted item neither committed nor pending");

   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && stat.out_busy) |=> !cmd.accept)
      else $error("new item accepted while one is still pending");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !stat.out_busy)
      else $error("commit while result register is occupied");

endmodule

`default_nettype wire

// ===== hdl/fbpa_datapath.sv =====
`default_nettype none

module fbpa_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fbpa_pkg::cmd_type  cmd,
   output fbpa_pkg::stat_type      stat,
   input  wire logic               req_type,
   input  wire logic [7:0]         req_block_index,
   input  wire logic               csr_valid,
   input  wire logic               csr_index,
   input  wire logic [12:0]        csr_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [7:0]              rsp_given_index,
   output logic [19:0]             rsp_block_offset,
   output logic [12:0]             rsp_clear_bytes,
   output logic [8:0]              rsp_free_blocks
);
   import fbpa_pkg::*;

   // Configuration registers.
   logic [12:0] block_bytes_ff, block_bytes_in;
   logic [8:0]  pool_blocks_ff, pool_blocks_in;

   // Pool state.
   logic [INDEX_W-1:0] list_head_ff, list_head_in;
   logic               list_nonempty_ff, list_nonempty_in;
   logic [8:0]         fresh_next_ff, fresh_next_in;
   logic [8:0]         free_total_ff, free_total_in;

   // Latched request.
   req_kind_type       kind_ff;
   logic [7:0]         index_ff;

   // Link memory: each word holds {entry below exists, index below}.
   logic [INDEX_W:0]   link_mem [NUM_BLOCKS];
   logic [INDEX_W:0]   link_rd_ff;
   logic               link_we;
   logic [INDEX_W:0]   link_wdata;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [7:0]  given_ff, given_in;
   logic [19:0] offset_ff, offset_in;
   logic [12:0] clear_ff, clear_in;
   logic [8:0]  free_out_ff;

   logic [12:0] e_bytes;
   logic [12:0] stride;
   logic [8:0]  n_blk;
   logic [20:0] offset_full;
   logic        got;

   assign e_bytes  = eff_bytes(block_bytes_ff);
   assign stride   = stride_of(e_bytes);
   assign n_blk    = eff_blocks(pool_blocks_ff);
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      block_bytes_in   = block_bytes_ff;
      pool_blocks_in   = pool_blocks_ff;
      list_head_in     = list_head_ff;
      list_nonempty_in = list_nonempty_ff;
      fresh_next_in    = fresh_next_ff;
      free_total_in    = free_total_ff;
      link_we          = 1'b0;
      link_wdata       = {list_nonempty_ff, list_head_ff};
      status_in        = STATUS_OK;
      given_in         = 8'd0;
      offset_in        = 20'd0;
      offset_full      = 21'd0;
      clear_in         = 13'd0;
      got              = 1'b0;

      if (cmd.commit) begin
         if (kind_ff == REQ_ALLOC) begin
            if (list_nonempty_ff) begin
               given_in         = 8'(list_head_ff);
               list_head_in     = link_rd_ff[INDEX_W-1:0];
               list_nonempty_in = link_rd_ff[INDEX_W];
               got              = 1'b1;
            end else if (fresh_next_ff < n_blk) begin
               given_in      = fresh_next_ff[7:0];
               fresh_next_in = fresh_next_ff + 9'd1;
               got           = 1'b1;
            end
            if (got) begin
               offset_full = 21'(given_in) * 21'(stride);
               offset_in   = offset_full[19:0];
               clear_in    = e_bytes;
               if (free_total_ff != 9'd0) free_total_in = free_total_ff - 9'd1;
            end else begin
               status_in = STATUS_EMPTY;
            end
         end else begin
            if ({1'b0, index_ff} >= n_blk) begin
               status_in = STATUS_RANGE;
            end else begin
               link_we          = 1'b1;
               list_head_in     = INDEX_W'(index_ff);
               list_nonempty_in = 1'b1;
               if (free_total_ff != FREE_SAT) free_total_in = free_total_ff + 9'd1;
            end
         end
      end

      // A register write puts every block back on the free side.
      if (csr_valid) begin
         if (csr_index == CSR_BLOCK_BYTES) begin
            block_bytes_in = csr_data;
            free_total_in  = n_blk;
         end else begin
            pool_blocks_in = csr_data[8:0];
            free_total_in  = eff_blocks(csr_data[8:0]);
         end
         list_head_in     = '0;
         list_nonempty_in = 1'b0;
         fresh_next_in    = 9'd0;
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff   <= BYTES_RESET;
         pool_blocks_ff   <= BLOCKS_RESET;
         list_head_ff     <= '0;
         list_nonempty_ff <= 1'b0;
         fresh_next_ff    <= 9'd0;
         free_total_ff    <= eff_blocks(BLOCKS_RESET);
         rsp_valid_ff     <= 1'b0;
      end else begin
         block_bytes_ff   <= block_bytes_in;
         pool_blocks_ff   <= pool_blocks_in;
         list_head_ff     <= list_head_in;
         list_nonempty_ff <= list_nonempty_in;
         fresh_next_ff    <= fresh_next_in;
         free_total_ff    <= free_total_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff  <= req_kind_type'(req_type);
         index_ff <= req_block_index;
      end
      if (cmd.commit) begin
         status_ff   <= status_in;
         given_ff    <= given_in;
         offset_ff   <= offset_in;
         clear_ff    <= clear_in;
         free_out_ff <= free_total_in;
      end
   end

   // Link memory: written on a committed free, read at the head on accept.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[INDEX_W'(index_ff)] <= link_wdata;
      end
      if (cmd.accept) begin
         link_rd_ff <= link_mem[list_head_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_given_index  = given_ff;
   assign rsp_block_offset = offset_ff;
   assign rsp_clear_bytes  = clear_ff;
   assign rsp_free_blocks  = free_out_ff;

   a_fresh_bounded: assert property (@(posedge clock) disable iff (reset)
      fresh_next_ff <= BLOCKS_MAX)
      else $error("fresh block counter beyond pool");

   a_commit_loads_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed item did not reach the result register");

   a_free_pushes: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !csr_valid && kind_ff == REQ_FREE && status_in == STATUS_OK)
      |=> (list_nonempty_ff && list_head_ff == INDEX_W'($past(index_ff))))
      else $error("accepted free did not become list head");

endmodule

`default_nettype wire
